// ----- rtl/hec_pkg.sv -----
`default_nettype none

package hec_pkg;

    localparam int WORD_W              = 63;
    localparam int POS_W               = 6;
    localparam int DLEN_W              = 6;
    localparam int MAX_PARITY_BITS_DEF = 6;
    localparam int DATA_LENGTH_RESET   = 4;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 72;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-3:0] REG_DATA_LENGTH = 1'b0;

    typedef enum logic
    {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } opcode_t;

    // Parity positions are the powers of two below 2**np
    function automatic bit is_parity_pos(input int q, input int np);
        return (q != 0) && ((q & (q - 1)) == 0) && (q < (1 << np));
    endfunction

    // 1-based codeword position of data bit j
    function automatic int data_pos(input int j, input int np);
        int cnt;
        int pos;
        cnt = 0;
        pos = 0;
        for (int q = 1; q < 128; q++)
        begin
            if (pos == 0 && !is_parity_pos(q, np))
            begin
                if (cnt == j)
                    pos = q;
                cnt++;
            end
        end
        return pos;
    endfunction

    // Codeword length for dlen data bits: dlen plus the number of parity bits that dlen needs
    function automatic int code_length(input int dlen, input int np);
        int r;
        r = np;
        for (int t = np; t >= 0; t--)
        begin
            if ((1 << t) - t - 1 >= dlen)
                r = t;
        end
        return dlen + r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/hamming_encode_and_correct.sv -----
// One word per cycle; the pipeline only holds when m_axis_tready is low.
// Stages: scatter/mask, parity trees, correction and parity insertion.
// Reset (rst_n low, asynchronous) empties the pipeline and sets data_length to 4.
// A data_length write takes effect in the cycle after the APB access cycle.
`default_nettype none

module hamming_encode_and_correct
    import hec_pkg::*;
#(
    parameter int MAX_PARITY_BITS = MAX_PARITY_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [62:0] word_in, [63] zero
    input  wire logic                   s_axis_tuser,   // [0] opcode

    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // [62:0] word_out, [68:63] error_position, [71:69] zero
    output logic                        m_axis_tuser,   // [0] uncorrectable

    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]       prdata,
    output logic                        pready
);

    localparam int NP       = MAX_PARITY_BITS;
    localparam int CW_W     = (1 << NP) - 1;
    localparam int DATA_MAX = CW_W - NP;
    localparam logic [NP-1:0] DLEN_RST =
        NP'((DATA_LENGTH_RESET > DATA_MAX) ? DATA_MAX : DATA_LENGTH_RESET);
    localparam logic [NP-1:0] LEN_RST =
        NP'(code_length(int'(DLEN_RST), NP));

    // configuration
    logic [DLEN_W-1:0] data_length_reg;
    logic [DLEN_W-1:0] data_length_next;
    logic [DLEN_W-1:0] dlen_cap;
    logic [NP-1:0]     dlen_reg;
    logic [NP-1:0]     len_reg;
    logic              reg_sel;
    logic              cfg_write;

    // pipeline
    logic              v1_reg, v2_reg, v3_reg;
    logic              adv1, adv2, adv3;
    opcode_t           op1_reg, op2_reg;
    logic [CW_W-1:0]   cw1_reg, cw1_next;
    logic [CW_W-1:0]   cw2_reg;
    logic [NP-1:0]     syn2_reg, syn2_next;
    logic [WORD_W-1:0] word3_reg;
    logic [CW_W-1:0]   word3_next;
    logic [POS_W-1:0]  pos3_reg, pos3_next;
    logic              bad3_reg, bad3_next;
    logic [CW_W-1:0]   cmask;

    assign pready    = 1'b1;
    assign reg_sel   = (paddr[APB_ADDR_W-1:2] == REG_DATA_LENGTH);
    assign cfg_write = psel && penable && pwrite && pready && reg_sel;

    always_comb
    begin
        prdata = '0;
        if (reg_sel)
            prdata = APB_DATA_W'(data_length_reg);
    end

    assign data_length_next = cfg_write ? pwdata[DLEN_W-1:0] : data_length_reg;
    assign dlen_cap = (data_length_next > DLEN_W'(DATA_MAX)) ? DLEN_W'(DATA_MAX)
                                                             : data_length_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_length_reg <= DLEN_W'(DATA_LENGTH_RESET);
            dlen_reg        <= DLEN_RST;
            len_reg         <= LEN_RST;
        end
        else
        begin
            data_length_reg <= data_length_next;
            dlen_reg        <= NP'(dlen_cap);
            len_reg         <= NP'(code_length(int'(dlen_cap), NP));
        end
    end

    // Stall-able pipeline: a stage advances when empty or when the next one advances
    assign adv3          = !v3_reg || m_axis_tready;
    assign adv2          = !v2_reg || adv3;
    assign adv1          = !v1_reg || adv2;
    assign s_axis_tready = adv1;

    // Stage 1: mask the input, scatter data bits on encode
    always_comb
    begin
        logic [CW_W-1:0] enc;
        enc = '0;
        for (int i = 0; i < CW_W; i++)
            cmask[i] = (NP'(i) < len_reg);
        for (int j = 0; j < DATA_MAX; j++)
            enc[NP'(data_pos(j, NP) - 1)] = s_axis_tdata[j] && (NP'(j) < dlen_reg);
        if (opcode_t'(s_axis_tuser) == OP_ENCODE)
            cw1_next = enc;
        else
            cw1_next = s_axis_tdata[CW_W-1:0] & cmask;
    end

    // Stage 2: one parity tree per parity position
    always_comb
    begin
        syn2_next = '0;
        for (int k = 0; k < NP; k++)
            for (int i = 0; i < CW_W; i++)
                if ((((i + 1) >> k) & 1) == 1)
                    syn2_next[k] = syn2_next[k] ^ cw1_reg[i];
    end

    // Stage 3: insert parity bits, or flip the named position unless it lies beyond the codeword length
    always_comb
    begin
        word3_next = cw2_reg;
        pos3_next  = '0;
        bad3_next  = 1'b0;
        if (op2_reg == OP_ENCODE)
        begin
            for (int k = 0; k < NP; k++)
                word3_next[NP'((1 << k) - 1)] = syn2_reg[k];
        end
        else
        begin
            pos3_next = POS_W'(syn2_reg);
            bad3_next = (syn2_reg != '0) && (syn2_reg > len_reg);
            for (int i = 0; i < CW_W; i++)
                word3_next[i] = cw2_reg[i] ^ ((syn2_reg == NP'(i + 1)) && !bad3_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= s_axis_tvalid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            op1_reg <= opcode_t'(s_axis_tuser);
            cw1_reg <= cw1_next;
        end
        if (adv2)
        begin
            op2_reg  <= op1_reg;
            cw2_reg  <= cw1_reg;
            syn2_reg <= syn2_next;
        end
        if (adv3)
        begin
            word3_reg <= WORD_W'(word3_next);
            pos3_reg  <= pos3_next;
            bad3_reg  <= bad3_next;
        end
    end

    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({pos3_reg, word3_reg});
    assign m_axis_tuser  = bad3_reg;

    a_bad_has_syndrome: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && bad3_reg |-> pos3_reg != '0)
        else $error("uncorrectable flagged with zero syndrome");

    a_bad_beyond_length: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && bad3_reg |-> pos3_reg > POS_W'(len_reg))
        else $error("uncorrectable flagged within codeword length");

    a_tail_clear: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> (word3_reg[CW_W-1:0] & ~cmask) == '0)
        else $error("result word has bits beyond codeword length");

endmodule

`default_nettype wire
